// ===== src/tts_pkg.sv =====
// Shared types and constants for the tiled texture swizzle address generator.
package tts_pkg;

  localparam int DIM_W  = 11;
  localparam int ADDR_W = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] DIM_RESET = 11'd8;

  localparam logic [5:0] TEXEL_LAST = 6'd63;

  localparam logic [5:0] ZORDER [64] = '{
    6'd0,  6'd1,  6'd4,  6'd5,  6'd16, 6'd17, 6'd20, 6'd21,
    6'd2,  6'd3,  6'd6,  6'd7,  6'd18, 6'd19, 6'd22, 6'd23,
    6'd8,  6'd9,  6'd12, 6'd13, 6'd24, 6'd25, 6'd28, 6'd29,
    6'd10, 6'd11, 6'd14, 6'd15, 6'd26, 6'd27, 6'd30, 6'd31,
    6'd32, 6'd33, 6'd36, 6'd37, 6'd48, 6'd49, 6'd52, 6'd53,
    6'd34, 6'd35, 6'd38, 6'd39, 6'd50, 6'd51, 6'd54, 6'd55,
    6'd40, 6'd41, 6'd44, 6'd45, 6'd56, 6'd57, 6'd60, 6'd61,
    6'd42, 6'd43, 6'd46, 6'd47, 6'd58, 6'd59, 6'd62, 6'd63
  };

  typedef struct packed {
    logic [ADDR_W-1:0] dst;
    logic              src_hit;
    logic              last;
    logic [DIM_W-1:0]  lx;
    logic [DIM_W-1:0]  ly_flip;
  } texel_t;

endpackage

// ===== src/tts_walk.sv =====
// Texel walker: tile and texel position counters and the texel register.
module tts_walk #(
  parameter int TC_W = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      ld,
  input  logic                      restart,
  input  logic [tts_pkg::DIM_W-1:0] w,
  input  logic [tts_pkg::DIM_W-1:0] h,
  output tts_pkg::texel_t           texel_r
);

  localparam int LOG_W = (TC_W > 1) ? $clog2(TC_W + 1) : 1;

  function automatic logic [LOG_W-1:0] tiles_log(input logic [tts_pkg::DIM_W-1:0] d);
    logic [LOG_W-1:0] r;
    r = '0;
    for (int i = 0; i < TC_W; i++) begin
      if ({1'b0, d} > (12'd8 << i)) r = LOG_W'(i + 1);
    end
    return r;
  endfunction

  logic [TC_W-1:0]           col_r, row_r;
  logic [5:0]                k_r;

  logic [TC_W-1:0]           col_nxt, row_nxt, col, row;
  logic [5:0]                k_nxt, k, off;
  logic [tts_pkg::ADDR_W-1:0] dst;
  logic [LOG_W-1:0]          log_w, log_h;
  logic [2*TC_W-1:0]         tile_idx;
  logic [TC_W:0]             tiles_w, tiles_h;
  logic                      wrap, last_col, last_row, last;
  logic [TC_W+2:0]           lx, ly;
  tts_pkg::texel_t           texel;

  assign log_w   = tiles_log(w);
  assign log_h   = tiles_log(h);
  assign tiles_w = (TC_W+1)'(1) << log_w;
  assign tiles_h = (TC_W+1)'(1) << log_h;

  assign wrap = restart || ({1'b0, col_r} >= tiles_w) || ({1'b0, row_r} >= tiles_h);
  assign col  = wrap ? '0 : col_r;
  assign row  = wrap ? '0 : row_r;
  assign k    = wrap ? '0 : k_r;

  assign tile_idx = ((2*TC_W)'(row) << log_w) + (2*TC_W)'(col);
  assign dst      = tts_pkg::ADDR_W'({tile_idx, k});

  assign off = tts_pkg::ZORDER[k];
  assign lx  = {col, off[2:0]};
  assign ly  = {row, off[5:3]};

  assign last_col = ({1'b0, col} == tiles_w - (TC_W+1)'(1));
  assign last_row = ({1'b0, row} == tiles_h - (TC_W+1)'(1));
  assign last     = (k == tts_pkg::TEXEL_LAST) && last_col && last_row;

  always_comb begin
    texel.dst     = dst;
    texel.src_hit = (12'(lx) < {1'b0, w}) && (12'(ly) < {1'b0, h});
    texel.last    = last;
    texel.lx      = tts_pkg::DIM_W'(lx);
    texel.ly_flip = h - tts_pkg::DIM_W'(ly) - 11'd1;
  end

  always_comb begin
    k_nxt   = k + 6'd1;
    col_nxt = col;
    row_nxt = row;
    if (k == tts_pkg::TEXEL_LAST) begin
      k_nxt = '0;
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row + TC_W'(1);
      end else begin
        col_nxt = col + TC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      k_r   <= '0;
    end else if (ld) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      k_r   <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      texel_r <= texel;
    end
  end

endmodule

// ===== src/tts_addr.sv =====
// Source address stage: flipped row times width plus column, result register.
module tts_addr (
  input  logic                       clk,
  input  logic                       ld,
  input  tts_pkg::texel_t            texel,
  input  logic [tts_pkg::DIM_W-1:0]  w,
  output logic [tts_pkg::ADDR_W-1:0] dst_index_r,
  output logic                       src_read_r,
  output logic [tts_pkg::ADDR_W-1:0] src_index_r,
  output logic                       last_texel_r
);

  logic [2*tts_pkg::DIM_W-1:0] prod;
  logic [2*tts_pkg::DIM_W-1:0] sum;
  logic [tts_pkg::ADDR_W-1:0]  src_index_nxt;

  assign prod = texel.ly_flip * w;
  assign sum  = prod + (2*tts_pkg::DIM_W)'(texel.lx);
  assign src_index_nxt = texel.src_hit ? sum[tts_pkg::ADDR_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (ld) begin
      dst_index_r  <= texel.dst;
      src_read_r   <= texel.src_hit;
      src_index_r  <= src_index_nxt;
      last_texel_r <= texel.last;
    end
  end

endmodule

// ===== src/tiled_texture_swizzle_address_gen_core.sv =====
// Top level of the tiled texture swizzle address generator.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | in_restart
//  out     | output    | out_valid/out_ready | out_dst_index, out_src_read,
//          |           |                     | out_src_index, out_last_texel
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One texel per cycle while the result is not stalled; a texel passes the
// walker register, then the result register after the source multiply.
// A stalled result holds both stages; input is taken whenever the walker
// register is empty or moves on. cfg_ready is always high.
// Reset returns the position to the first texel and the sizes to 8x8.
module tiled_texture_swizzle_address_gen_core #(
  parameter int MAX_DIM = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tts_pkg::ADDR_W-1:0]    out_dst_index,
  output logic                          out_src_read,
  output logic [tts_pkg::ADDR_W-1:0]    out_src_index,
  output logic                          out_last_texel,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tts_pkg::DIM_W-1:0]     cfg_data
);

  localparam int MAX_EFF   = (MAX_DIM > 2047) ? 2047 : MAX_DIM;
  localparam int MAX_TILES = (1 << $clog2(MAX_EFF)) / 8;
  localparam int TC_W      = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam logic [tts_pkg::DIM_W-1:0] DIM_CLAMP = tts_pkg::DIM_W'(MAX_EFF);

  logic [tts_pkg::DIM_W-1:0] src_width_r, src_height_r, w, h;
  logic                      valid_a_r, out_valid_r;
  logic                      a_ready, b_ready, in_xfer, a_xfer;
  tts_pkg::texel_t           texel_a;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= tts_pkg::DIM_RESET;
      src_height_r <= tts_pkg::DIM_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        tts_pkg::CFG_SRC_WIDTH:  src_width_r  <= cfg_data;
        tts_pkg::CFG_SRC_HEIGHT: src_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w = (src_width_r  > DIM_CLAMP) ? DIM_CLAMP : src_width_r;
  assign h = (src_height_r > DIM_CLAMP) ? DIM_CLAMP : src_height_r;

  assign b_ready  = !out_valid_r || out_ready;
  assign a_ready  = !valid_a_r || b_ready;
  assign in_ready = a_ready;
  assign in_xfer  = in_valid && a_ready;
  assign a_xfer   = valid_a_r && b_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        valid_a_r <= 1'b1;
      end else if (a_xfer) begin
        valid_a_r <= 1'b0;
      end
      if (a_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

  tts_walk #(
    .TC_W (TC_W)
  ) u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .ld      (in_xfer),
    .restart (in_restart),
    .w       (w),
    .h       (h),
    .texel_r (texel_a)
  );

  tts_addr u_addr (
    .clk          (clk),
    .ld           (a_xfer),
    .texel        (texel_a),
    .w            (w),
    .dst_index_r  (out_dst_index),
    .src_read_r   (out_src_read),
    .src_index_r  (out_src_index),
    .last_texel_r (out_last_texel)
  );

endmodule

// ===== src/tts_checker.sv =====
// Port-level checks for the tiled texture swizzle address generator.
module tts_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tts_pkg::ADDR_W-1:0]    out_dst_index,
  input logic                          out_src_read,
  input logic [tts_pkg::ADDR_W-1:0]    out_src_index,
  input logic                          out_last_texel
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dst_index)
      && $stable(out_src_index) && $stable(out_src_read) && $stable(out_last_texel))
    else $error("stalled result changed");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_src_read |-> out_src_index == '0)
    else $error("padding texel with nonzero source index");

  a_last_tile_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_texel |-> out_dst_index[5:0] == tts_pkg::TEXEL_LAST)
    else $error("last texel not at end of tile");

  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tiled_texture_swizzle_address_gen_core tts_checker u_tts_checker (.*);
